// ===== rtl/ctd_pkg.sv =====
// Shared types, token kind codes and helpers for the compact token decoder.
// No dependencies.
package ctd_pkg;

  localparam logic [2:0] KIND_VAR32 = 3'd0;
  localparam logic [2:0] KIND_ZIG32 = 3'd1;
  localparam logic [2:0] KIND_VAR64 = 3'd2;
  localparam logic [2:0] KIND_ZIG64 = 3'd3;
  localparam logic [2:0] KIND_FIELD = 3'd4;
  localparam logic [2:0] KIND_LIST  = 3'd5;

  localparam logic [3:0] LIMIT32       = 4'd5;
  localparam logic [3:0] LIMIT64       = 4'd10;
  localparam logic [3:0] COUNT_MAX     = 4'd15;
  localparam logic [3:0] STOP_NIBBLE   = 4'h0;
  localparam logic [3:0] LONG_NIBBLE   = 4'hf;
  localparam logic [6:0] GROUP_MASK    = 7'h7f;
  localparam int         CONT_BIT      = 7;
  localparam logic [6:0] SHIFT_LIMIT   = 7'd64;

  typedef struct packed {
    logic done;      // continuation bit clear, token complete
    logic overflow;  // byte limit reached with continuation still set
  } feed_status_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic [63:0]        value;
    logic signed [15:0] fid;
    logic [3:0]         etype;
    logic               stop;
    logic               err;
  } result_t;

  function automatic logic [63:0] unzig64(input logic [63:0] u);
    unzig64 = {1'b0, u[63:1]} ^ {64{u[0]}};
  endfunction

  function automatic logic [31:0] unzig32(input logic [31:0] u);
    unzig32 = {1'b0, u[31:1]} ^ {32{u[0]}};
  endfunction

endpackage

// ===== rtl/ctd_feed.sv =====
// Varint group accumulator: merges one stream byte into the running value.
// Depends on ctd_pkg.
module ctd_feed (
  input  logic [7:0]            data_byte,
  input  logic [63:0]           acc_in,
  input  logic [3:0]            cnt_in,
  input  logic                  wide,
  output logic [63:0]           acc_next,
  output logic [3:0]            cnt_next,
  output ctd_pkg::feed_status_t status
);
  import ctd_pkg::*;

  logic [6:0]  sh;
  logic [63:0] grp_w;
  logic [3:0]  limit;

  assign sh    = {cnt_in, 3'b000} - {3'b000, cnt_in};  // cnt * 7
  assign grp_w = {57'b0, data_byte[6:0] & GROUP_MASK};
  assign limit = wide ? LIMIT64 : LIMIT32;

  always_comb begin
    acc_next = acc_in;
    if (sh < SHIFT_LIMIT) begin
      acc_next = acc_in | (grp_w << sh[5:0]);
    end
    cnt_next = (cnt_in == COUNT_MAX) ? COUNT_MAX : cnt_in + 4'd1;
    status.done     = !data_byte[CONT_BIT];
    status.overflow = data_byte[CONT_BIT] && (cnt_next >= limit);
  end

endmodule

// ===== rtl/compact_token_decoder.sv =====
// Compact-protocol token decoder: one stream byte per item, one result per token.
// A token's result is registered into the result register, or into the skid
// register while the output is held. Throughput: one byte per cycle while
// in_stall is low; the two-entry buffer lets input flow while one result waits.
// Reset (rst, synchronous, active high): idle, no token open, buffers empty.
// Depends on ctd_pkg and ctd_feed.
module compact_token_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         data_byte,
  input  logic [2:0]         token_kind,
  input  logic signed [15:0] prev_field_id,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         done_kind,
  output logic [63:0]        value,
  output logic signed [15:0] field_id,
  output logic [3:0]         elem_type,
  output logic               is_stop,
  output logic               error
);
  import ctd_pkg::*;

  // Token state
  logic        in_token, in_token_next;
  logic [2:0]  current_kind, current_kind_next;
  logic [63:0] accumulator, accumulator_next;
  logic [3:0]  byte_count, byte_count_next;
  logic [3:0]  saved_type, saved_type_next;

  // Output buffer
  result_t out_r, skid_r;
  logic    skid_valid;

  // Per-item decode
  logic         accept, out_take, slot_free, push;
  logic         feed_path, wide;
  logic [2:0]   kind_eff;
  logic [63:0]  acc_in, acc_fed;
  logic [3:0]   cnt_in, cnt_fed;
  feed_status_t fst;
  result_t      res_new;
  logic [3:0]   lo, hi;
  logic [3:0]   fin_type;
  logic [31:0]  fid_zz;

  assign in_stall  = skid_valid;
  assign accept    = in_valid && !skid_valid;
  assign out_take  = out_valid && !out_stall;
  assign slot_free = out_take || !out_valid;

  assign lo = data_byte[3:0];
  assign hi = data_byte[7:4];

  // A token in progress keeps feeding bytes; a new token is a varint if its
  // kind is one of the four integer kinds.
  assign feed_path = in_token || (token_kind <= KIND_ZIG64);
  assign kind_eff  = in_token ? current_kind : token_kind;
  assign wide      = (kind_eff == KIND_VAR64) || (kind_eff == KIND_ZIG64);
  assign acc_in    = in_token ? accumulator : '0;
  assign cnt_in    = in_token ? byte_count : '0;

  ctd_feed u_feed (
    .data_byte (data_byte),
    .acc_in    (acc_in),
    .cnt_in    (cnt_in),
    .wide      (wide),
    .acc_next  (acc_fed),
    .cnt_next  (cnt_fed),
    .status    (fst)
  );

  // Header kinds report their saved type nibble; integer kinds report zero.
  assign fin_type = (kind_eff >= KIND_FIELD) ? saved_type : 4'd0;
  assign fid_zz   = unzig32(acc_fed[31:0]);

  always_comb begin
    in_token_next     = in_token;
    current_kind_next = current_kind;
    accumulator_next  = accumulator;
    byte_count_next   = byte_count;
    saved_type_next   = saved_type;
    push              = 1'b0;
    res_new           = '0;

    if (feed_path) begin
      current_kind_next = kind_eff;
      accumulator_next  = acc_fed;
      byte_count_next   = cnt_fed;
      in_token_next     = 1'b1;
      res_new.kind      = kind_eff;
      if (fst.overflow) begin
        // Too many bytes: error result, value and id cleared.
        in_token_next = 1'b0;
        push          = 1'b1;
        res_new.etype = fin_type;
        res_new.err   = 1'b1;
      end else if (fst.done) begin
        in_token_next = 1'b0;
        push          = 1'b1;
        case (kind_eff)
          KIND_VAR32: res_new.value = {32'b0, acc_fed[31:0]};
          KIND_ZIG32: res_new.value = {32'b0, unzig32(acc_fed[31:0])};
          KIND_VAR64: res_new.value = acc_fed;
          KIND_ZIG64: res_new.value = unzig64(acc_fed);
          KIND_FIELD: begin
            // Long-form id: zigzag i16 from the low bits.
            res_new.fid   = fid_zz[15:0];
            res_new.etype = fin_type;
          end
          default: begin
            // List with long size form.
            res_new.value = {32'b0, acc_fed[31:0]};
            res_new.etype = fin_type;
          end
        endcase
      end
    end else if (token_kind == KIND_FIELD) begin
      res_new.kind = KIND_FIELD;
      if (lo == STOP_NIBBLE) begin
        push         = 1'b1;
        res_new.stop = 1'b1;
      end else if (hi != 4'd0) begin
        // Short form: delta on the previous id, wraps in 16 bits.
        push          = 1'b1;
        res_new.fid   = prev_field_id + $signed({12'b0, hi});
        res_new.etype = lo;
      end else begin
        saved_type_next   = lo;
        current_kind_next = KIND_FIELD;
        accumulator_next  = '0;
        byte_count_next   = '0;
        in_token_next     = 1'b1;
      end
    end else if (token_kind == KIND_LIST) begin
      res_new.kind = KIND_LIST;
      if (hi != LONG_NIBBLE) begin
        push          = 1'b1;
        res_new.value = {60'b0, hi};
        res_new.etype = lo;
      end else begin
        saved_type_next   = lo;
        current_kind_next = KIND_LIST;
        accumulator_next  = '0;
        byte_count_next   = '0;
        in_token_next     = 1'b1;
      end
    end
    // Unknown kinds on a first byte: dropped, block stays idle.
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_token     <= 1'b0;
      current_kind <= '0;
      accumulator  <= '0;
      byte_count   <= '0;
      saved_type   <= '0;
    end else if (accept) begin
      in_token     <= in_token_next;
      current_kind <= current_kind_next;
      accumulator  <= accumulator_next;
      byte_count   <= byte_count_next;
      saved_type   <= saved_type_next;
    end
  end

  // Output register with skid stage. The skid only fills when a result is
  // produced while the output register is held; input stalls while it is full.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (slot_free) begin
      out_valid  <= skid_valid || (accept && push);
      skid_valid <= 1'b0;
    end else if (accept && push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free) begin
      out_r <= skid_valid ? skid_r : res_new;
    end else if (accept && push) begin
      skid_r <= res_new;
    end
  end

  assign done_kind = out_r.kind;
  assign value     = out_r.value;
  assign field_id  = out_r.fid;
  assign elem_type = out_r.etype;
  assign is_stop   = out_r.stop;
  assign error     = out_r.err;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a result while output register is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && out_stall |=> skid_valid)
    else $error("skid result lost under stall");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    in_token |-> byte_count < LIMIT64)
    else $error("open token past byte limit");

  a_kind_known: assert property (@(posedge clk) disable iff (rst)
    in_token |-> current_kind <= KIND_LIST)
    else $error("open token with unknown kind");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> value == 64'd0 && field_id == 16'sd0 && !is_stop)
    else $error("error result carries data");

endmodule
